/* rtl/lceg_pkg.sv */
package lceg_pkg;

  localparam int BREATH_STEPS = 315;
  localparam int PHASE_W = 9;

  // effect modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SOLID  = 2'd1;
  localparam logic [1:0] MODE_BREATH = 2'd2;
  localparam logic [1:0] MODE_SPEED  = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_SOLID_R    = 3'd1;
  localparam logic [2:0] REG_SOLID_G    = 3'd2;
  localparam logic [2:0] REG_SOLID_B    = 3'd3;
  localparam logic [2:0] REG_BRIGHTNESS = 3'd4;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_ACCEPT = 4'd1;
  localparam logic [3:0] OP_ROM    = 4'd2;
  localparam logic [3:0] OP_MUL    = 4'd3;
  localparam logic [3:0] OP_MAC    = 4'd4;
  localparam logic [3:0] OP_REDUCE = 4'd5;
  localparam logic [3:0] OP_SCALE  = 4'd6;
  localparam logic [3:0] OP_STORE  = 4'd7;
  localparam logic [3:0] OP_OUT    = 4'd8;

  localparam logic [13:0] SPEED_FULL = 14'd10240;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] ch;
  } cmd_t;

  typedef logic [15:0] inten_rom_t [BREATH_STEPS];

  localparam logic [63:0] Q28_ONE    = 64'd268435456;
  localparam logic [63:0] ANGLE_STEP = 64'd5368709;
  localparam logic [63:0] TWO_PI_Q28 = 64'd1686629713;
  localparam logic [63:0] PI_Q28     = 64'd843314857;
  localparam logic [63:0] HALF_PI    = 64'd421657428;

  function automatic logic [7:0] purple_of(input logic [1:0] ch);
    logic [7:0] c;
    case (ch)
      2'd0: c = 8'd195;
      2'd1: c = 8'd177;
      default: c = 8'd225;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] cyan_of(input logic [1:0] ch);
    logic [7:0] c;
    case (ch)
      2'd0: c = 8'd0;
      default: c = 8'd204;
    endcase
    return c;
  endfunction

  // (1 + sin(phase * 0.02)) / 2 as a q16 fraction, built at elaboration
  function automatic inten_rom_t build_inten_rom();
    inten_rom_t rom;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] f;
    logic [63:0] s;
    logic [63:0] v;
    logic neg;
    for (int p = 0; p < BREATH_STEPS; p++) begin
      t = (64'(p) * ANGLE_STEP) % TWO_PI_Q28;
      neg = 1'b0;
      if (t >= PI_Q28) begin
        neg = 1'b1;
        t = t - PI_Q28;
      end
      if (t > HALF_PI) t = PI_Q28 - t;
      t2 = (t * t) >> 28;
      f = Q28_ONE - t2 / 110;
      f = Q28_ONE - ((t2 * f) >> 28) / 72;
      f = Q28_ONE - ((t2 * f) >> 28) / 42;
      f = Q28_ONE - ((t2 * f) >> 28) / 20;
      f = Q28_ONE - ((t2 * f) >> 28) / 6;
      s = (t * f) >> 28;
      if (s > Q28_ONE) s = Q28_ONE;
      v = neg ? (Q28_ONE - s) : (Q28_ONE + s);
      v = v >> 13;
      if (v > 64'd65535) v = 64'd65535;
      rom[p] = v[15:0];
    end
    return rom;
  endfunction

  localparam inten_rom_t INTEN_ROM = build_inten_rom();

endpackage

/* rtl/lceg_ctrl.sv */
module lceg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output lceg_pkg::cmd_t cmd
);
  import lceg_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROM   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_MAC   = 3'd3;
  localparam logic [2:0] S_RED   = 3'd4;
  localparam logic [2:0] S_SCALE = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] ch;
  logic [1:0] ch_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ch_next = ch;
    out_valid_next = out_valid && !out_ready;
    cmd.op = OP_NONE;
    cmd.ch = ch;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
          state_next = S_ROM;
        end
      end
      S_ROM: begin
        cmd.op = OP_ROM;
        ch_next = 2'd0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op = OP_MUL;
        state_next = S_MAC;
      end
      S_MAC: begin
        cmd.op = OP_MAC;
        state_next = S_RED;
      end
      S_RED: begin
        cmd.op = OP_REDUCE;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = OP_SCALE;
        state_next = S_STORE;
      end
      S_STORE: begin
        cmd.op = OP_STORE;
        if (ch == 2'd2) begin
          state_next = S_OUT;
        end else begin
          ch_next = ch + 2'd1;
          state_next = S_MUL;
        end
      end
      S_OUT: begin
        // wait for the output word to be free
        if (!out_valid || out_ready) begin
          cmd.op = OP_OUT;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ch <= ch_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* rtl/lceg_datapath.sv */
module lceg_datapath (
  input  logic           clk,
  input  logic           rst,
  input  lceg_pkg::cmd_t cmd,
  input  logic [15:0]    speed_fixed,
  input  logic           cfg_valid,
  input  logic [2:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue
);
  import lceg_pkg::*;

  logic [1:0]         effect_mode;
  logic [7:0]         solid_red;
  logic [7:0]         solid_green;
  logic [7:0]         solid_blue;
  logic [7:0]         global_brightness;
  logic [PHASE_W-1:0] breath_phase;
  logic [13:0]        speed_sat;
  logic [15:0]        intensity;
  logic [24:0]        acc;
  logic [7:0]         chan_val;
  logic [7:0]         res [3];

  logic [7:0]  mul_a;
  logic [16:0] mul_b;
  logic [24:0] prod;
  logic [7:0]  purple;
  logic [7:0]  cyan;
  logic [7:0]  solid;
  logic [26:0] fifth;
  logic [16:0] div255;
  logic [7:0]  reduced;

  assign purple = purple_of(cmd.ch);
  assign cyan = cyan_of(cmd.ch);

  always_comb begin
    case (cmd.ch)
      2'd0: solid = solid_red;
      2'd1: solid = solid_green;
      default: solid = solid_blue;
    endcase
  end

  // shared 8x17 multiplier
  always_comb begin
    mul_a = 8'd0;
    mul_b = 17'd0;
    case (cmd.op)
      OP_MUL: begin
        if (effect_mode == MODE_SPEED) begin
          mul_a = cyan;
          mul_b = {3'b0, SPEED_FULL - speed_sat};
        end else begin
          mul_a = purple;
          mul_b = 17'h10000 - {1'b0, intensity};
        end
      end
      OP_MAC: begin
        if (effect_mode == MODE_SPEED) begin
          mul_a = purple;
          mul_b = {3'b0, speed_sat};
        end else begin
          mul_a = cyan;
          mul_b = {1'b0, intensity};
        end
      end
      OP_SCALE: begin
        mul_a = chan_val;
        mul_b = {9'b0, global_brightness};
      end
      default: begin
        mul_a = 8'd0;
        mul_b = 17'd0;
      end
    endcase
  end

  assign prod = {17'b0, mul_a} * {8'b0, mul_b};

  // divide by 10240: shift by 11, then times 52429 >> 18 for the divide by 5
  assign fifth = {16'b0, acc[21:11]} * 27'd52429;

  always_comb begin
    case (effect_mode)
      MODE_SOLID:  reduced = solid;
      MODE_BREATH: reduced = acc[23:16];
      MODE_SPEED:  reduced = fifth[25:18];
      default:     reduced = 8'd0;
    endcase
  end

  // exact floor(x / 255) for x up to 65279, which covers every 8-bit by 8-bit product
  assign div255 = {1'b0, acc[15:0]} + 17'd1 + {9'b0, acc[15:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode <= MODE_BREATH;
      solid_red <= 8'd195;
      solid_green <= 8'd177;
      solid_blue <= 8'd225;
      global_brightness <= 8'd255;
      breath_phase <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:       effect_mode <= cfg_data[1:0];
          REG_SOLID_R:    solid_red <= cfg_data;
          REG_SOLID_G:    solid_green <= cfg_data;
          REG_SOLID_B:    solid_blue <= cfg_data;
          REG_BRIGHTNESS: global_brightness <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ACCEPT && effect_mode == MODE_BREATH) begin
        if (breath_phase >= PHASE_W'(BREATH_STEPS - 1)) begin
          breath_phase <= '0;
        end else begin
          breath_phase <= breath_phase + PHASE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        speed_sat <= (speed_fixed > {2'b0, SPEED_FULL}) ? SPEED_FULL : speed_fixed[13:0];
      end
      OP_ROM: begin
        intensity <= INTEN_ROM[breath_phase];
      end
      OP_MUL: begin
        acc <= prod;
      end
      OP_MAC: begin
        acc <= acc + prod;
      end
      OP_REDUCE: begin
        chan_val <= reduced;
      end
      OP_SCALE: begin
        acc <= prod;
      end
      OP_STORE: begin
        res[cmd.ch] <= div255[15:8];
      end
      OP_OUT: begin
        out_red <= res[0];
        out_green <= res[1];
        out_blue <= res[2];
      end
      default: ;
    endcase
  end

endmodule

/* rtl/led_color_effect_generator.sv */
// LED strip color effect generator: one strip color per frame tick.
// Input channel (in_valid/in_ready, speed_fixed): one word per frame tick,
// carrying vehicle speed in 1/256 km/h. Output channel (out_valid/out_ready,
// out_red/out_green/out_blue): one color word per input word.
// Config channel (cfg_valid/cfg_ready, cfg_index/cfg_data): always ready;
// index 0 mode, 1..3 solid color, 4 brightness; other indexes are ignored.
// Write config only while the block is idle.
// The result word is loaded into the output register after all steps for the
// word are done; a new word is accepted only once the block is idle again.
// The work runs as five steps per color channel around one shared 8x17
// multiplier (blend, blend accumulate, reduce, brightness, divide by 255)
// for three channels, plus one breathing rom read and one output load.
// Reset restores the register defaults (breathing mode, full brightness)
// and zeroes the breathing phase; no output word is pending.
// If the receiver stalls, the finished word is held in the output register
// and the next input word is still taken and worked on; its result waits
// until the held word is taken.
module led_color_effect_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] speed_fixed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import lceg_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lceg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lceg_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .speed_fixed (speed_fixed),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue)
  );

endmodule

/* dv/tb_led_color_effect_generator.sv */
module tb_led_color_effect_generator;
  import lceg_pkg::*;

  localparam logic [63:0] ONE_Q28     = 64'd268435456;
  localparam logic [63:0] STEP_Q28    = 64'd5368709;
  localparam logic [63:0] FULL_TURN   = 64'd1686629713;
  localparam logic [63:0] HALF_TURN   = 64'd843314857;
  localparam logic [63:0] QUARTER     = 64'd421657428;
  localparam logic [31:0] SPEED_SAT   = 32'd10240;
  localparam int          SEG_ITEMS   = 106;
  localparam int          SETTLE      = 40;
  localparam int          LONG_HOLD   = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] speed_fixed = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [7:0]  cfg_data = 8'd0;

  led_color_effect_generator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .speed_fixed(speed_fixed),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers and breathing phase
  logic [1:0] fx_mode;
  logic [7:0] fx_solid [3];
  logic [7:0] fx_bright;
  logic [8:0] fx_phase;

  logic [15:0] pending_speeds [$];
  color_t      expected_colors [$];
  int          err_cnt = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        tx_pause = 1'b0;
  logic        rx_hold_go = 1'b0;
  int unsigned rx_hold_left = 0;

  // (1 + sin(phase * 0.02)) / 2 in q16, fixed-point taylor series
  function automatic logic [15:0] breath_level(input logic [8:0] ph);
    logic [63:0] ang;
    logic [63:0] ang2;
    logic [63:0] acc;
    logic [63:0] mag;
    logic [63:0] lvl;
    logic        lower;
    logic [63:0] divs [5];
    divs = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
    ang = (64'(ph) * STEP_Q28) % FULL_TURN;
    lower = 1'b0;
    if (ang >= HALF_TURN) begin
      lower = 1'b1;
      ang = ang - HALF_TURN;
    end
    if (ang > QUARTER) ang = HALF_TURN - ang;
    ang2 = (ang * ang) >> 28;
    acc = ONE_Q28;
    for (int i = 0; i < 5; i++) acc = ONE_Q28 - ((ang2 * acc) >> 28) / divs[i];
    mag = (ang * acc) >> 28;
    if (mag > ONE_Q28) mag = ONE_Q28;
    lvl = lower ? (ONE_Q28 - mag) : (ONE_Q28 + mag);
    lvl = lvl >> 13;
    if (lvl > 64'd65535) lvl = 64'd65535;
    return lvl[15:0];
  endfunction

  // color for one frame tick; advances the breathing phase in breathing mode
  function automatic color_t next_color(input logic [15:0] spd);
    color_t      c;
    logic [31:0] ch [3];
    logic [31:0] purple [3];
    logic [31:0] cyan [3];
    logic [31:0] lvl;
    logic [31:0] s;
    purple = '{32'd195, 32'd177, 32'd225};
    cyan = '{32'd0, 32'd204, 32'd204};
    ch = '{32'd0, 32'd0, 32'd0};
    case (fx_mode)
      MODE_SOLID: begin
        for (int k = 0; k < 3; k++) ch[k] = 32'(fx_solid[k]);
      end
      MODE_BREATH: begin
        if (32'(fx_phase) >= BREATH_STEPS - 1) fx_phase = 9'd0;
        else fx_phase = fx_phase + 9'd1;
        lvl = 32'(breath_level(fx_phase));
        for (int k = 0; k < 3; k++)
          ch[k] = (purple[k] * (32'd65536 - lvl) + cyan[k] * lvl) >> 16;
      end
      MODE_SPEED: begin
        s = (32'(spd) > SPEED_SAT) ? SPEED_SAT : 32'(spd);
        for (int k = 0; k < 3; k++)
          ch[k] = (cyan[k] * (SPEED_SAT - s) + purple[k] * s) / SPEED_SAT;
      end
      default: ;
    endcase
    for (int k = 0; k < 3; k++) ch[k] = (ch[k] * 32'(fx_bright)) / 32'd255;
    c.red = ch[0][7:0];
    c.green = ch[1][7:0];
    c.blue = ch[2][7:0];
    return c;
  endfunction

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(0, 10240));
      5: return 16'd10240;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 3))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MODE: fx_mode = val[1:0];
      REG_SOLID_R: fx_solid[0] = val;
      REG_SOLID_G: fx_solid[1] = val;
      REG_SOLID_B: fx_solid[2] = val;
      REG_BRIGHTNESS: fx_bright = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until every word is sent and answered, then let the pipe settle
  // checked at the falling edge so the driver's updates have landed
  task automatic drain();
    while (pending_speeds.size() != 0 || in_valid || expected_colors.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_colors.push_back(next_color(speed_fixed));
      if (!in_valid || in_ready) begin
        if (!tx_pause && pending_speeds.size() != 0 &&
            $urandom_range(0, 99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          speed_fixed <= pending_speeds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rx_hold_go) rx_hold_left <= LONG_HOLD;
    else if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (rx_hold_left != 0) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // output monitor
  always @(posedge clk) begin
    color_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        if (err_cnt < 10)
          $display("unexpected color word %0d/%0d/%0d", out_red, out_green, out_blue);
        err_cnt++;
      end else begin
        want = expected_colors.pop_front();
        if (want.red !== out_red || want.green !== out_green || want.blue !== out_blue) begin
          if (err_cnt < 10)
            $display("color mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                     want.red, want.green, want.blue, out_red, out_green, out_blue);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("tb_led_color_effect_generator: done, errors");
    $finish;
  end

  initial begin
    logic [1:0] seg_modes [8];
    seg_modes = '{MODE_BREATH, MODE_SPEED, MODE_SOLID, MODE_BREATH,
                  MODE_OFF, MODE_SPEED, MODE_BREATH, MODE_BREATH};
    fx_mode = MODE_BREATH;
    fx_solid = '{8'd195, 8'd177, 8'd225};
    fx_bright = 8'd255;
    fx_phase = 9'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // breathing with reset defaults
    pending_speeds.push_back(16'd0);
    pending_speeds.push_back(16'hFFFF);
    pending_speeds.push_back(16'd1234);
    drain();

    // speed mode around the saturation point
    write_reg(REG_MODE, 8'(MODE_SPEED));
    pending_speeds.push_back(16'd0);
    pending_speeds.push_back(16'd1);
    pending_speeds.push_back(16'd10239);
    pending_speeds.push_back(16'd10240);
    pending_speeds.push_back(16'd10241);
    pending_speeds.push_back(16'hFFFF);
    pending_speeds.push_back(16'd5120);
    drain();

    // solid color extremes, then zero and half brightness
    write_reg(REG_MODE, 8'(MODE_SOLID));
    write_reg(REG_SOLID_R, 8'd255);
    write_reg(REG_SOLID_G, 8'd0);
    write_reg(REG_SOLID_B, 8'd170);
    pending_speeds.push_back(16'd0);
    pending_speeds.push_back(16'hA5A5);
    drain();
    write_reg(REG_SOLID_R, 8'd0);
    write_reg(REG_SOLID_G, 8'd255);
    write_reg(REG_SOLID_B, 8'd85);
    pending_speeds.push_back(16'h5A5A);
    drain();
    write_reg(REG_BRIGHTNESS, 8'd0);
    pending_speeds.push_back(16'd100);
    drain();
    write_reg(REG_BRIGHTNESS, 8'd128);
    pending_speeds.push_back(16'd200);
    drain();

    // off mode
    write_reg(REG_MODE, 8'(MODE_OFF));
    write_reg(REG_BRIGHTNESS, 8'd255);
    pending_speeds.push_back(16'hFFFF);
    pending_speeds.push_back(16'd0);
    drain();

    // zero brightness in breathing and speed modes
    write_reg(REG_MODE, 8'(MODE_BREATH));
    write_reg(REG_BRIGHTNESS, 8'd0);
    pending_speeds.push_back(16'd7);
    pending_speeds.push_back(16'd8);
    drain();
    write_reg(REG_MODE, 8'(MODE_SPEED));
    pending_speeds.push_back(16'hFFFF);
    drain();

    // writes past the last register are dropped, mode takes only two bits
    for (int k = 1; k <= 3; k++) write_reg(REG_BRIGHTNESS + 3'(k), 8'($urandom));
    write_reg(REG_MODE, 8'hFE);
    write_reg(REG_BRIGHTNESS, 8'd1);
    pending_speeds.push_back(16'd3000);
    pending_speeds.push_back(16'd9000);
    drain();

    for (int seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin tx_idle_pct <= 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct <= 53; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct <= 0;  rx_stall_pct <= 53; end
        default: begin tx_idle_pct <= 18; rx_stall_pct <= 18; end
      endcase
      write_reg(REG_MODE, 8'(seg_modes[seg]));
      write_reg(REG_SOLID_R, rand_level());
      write_reg(REG_SOLID_G, rand_level());
      write_reg(REG_SOLID_B, rand_level());
      write_reg(REG_BRIGHTNESS, (seg == 0 || seg == 6) ? 8'd255 : rand_level());
      for (int n = 0; n < SEG_ITEMS; n++) pending_speeds.push_back(rand_speed());
      if (seg == 0) begin
        // receiver holds off while words keep coming, block backs up
        rx_hold_go <= 1'b1;
        @(posedge clk);
        rx_hold_go <= 1'b0;
      end
      if (seg == 3) begin
        while (pending_speeds.size() > SEG_ITEMS / 2) @(posedge clk);
        tx_pause <= 1'b1;
        @(posedge clk);
        while (in_valid || expected_colors.size() != 0) @(posedge clk);
        tx_pause <= 1'b0;
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("tb_led_color_effect_generator: done, clean");
    end else begin
      $display("tb_led_color_effect_generator: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/lceg_pkg.sv
rtl/lceg_ctrl.sv
rtl/lceg_datapath.sv
rtl/led_color_effect_generator.sv
dv/tb_led_color_effect_generator.sv
